### rtl/uvs_pkg.sv
`default_nettype none
package uvs_pkg;

    // quarter-wave polynomial coefficients, Q30
    localparam logic [30:0] TRIG_A = 31'd1686629713;
    localparam logic [29:0] TRIG_B = 30'd688904866;
    localparam logic [26:0] TRIG_C = 27'd76016977;

    // reset values of the configuration registers
    localparam logic [7:0]  RING_RESET   = 8'd5;
    localparam logic [15:0] RADIUS_RESET = 16'd256;
    // floor(2^32 / (2 * RING_RESET))
    localparam logic [31:0] RECIP_RESET  = 32'd429496729;

    // configuration register indexes
    localparam logic REG_RING   = 1'b0;
    localparam logic REG_RADIUS = 1'b1;

    localparam int RECIP_STEPS = 33;

    typedef struct packed {
        logic        busy;
        logic [31:0] recip;
    } t_recip_stat;

endpackage
`default_nettype wire

### rtl/uvs_recip.sv
`default_nettype none
module uvs_recip (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [8:0]        i_div,
    output uvs_pkg::t_recip_stat   o_stat
);
    import uvs_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [8:0]  r_rem;
    logic [31:0] r_quo;
    logic [8:0]  r_div;
    logic [31:0] r_recip;

    logic [9:0]  n_trial;
    logic        n_bit;
    logic [8:0]  n_rem;
    logic [31:0] n_quo;

    // one quotient bit of 2^32 / div per cycle, restoring
    always_comb begin
        n_trial = {r_rem, (r_cnt == 6'd0)};
        n_bit   = (n_trial >= {1'b0, r_div});
        n_rem   = n_bit ? 9'(n_trial - {1'b0, r_div}) : n_trial[8:0];
        n_quo   = {r_quo[30:0], n_bit};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_recip <= RECIP_RESET;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(RECIP_STEPS - 1)) begin
                r_busy  <= 1'b0;
                r_recip <= n_quo;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_div <= i_div;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.recip = r_recip;

endmodule
`default_nettype wire

### rtl/uvs_sine.sv
`default_nettype none
module uvs_sine (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [15:0]        i_phase,
    output logic signed [16:0]      o_sine
);
    import uvs_pkg::*;

    logic [14:0] r_x_a, r_x_b, r_x_c, r_x_d;
    logic        r_sg_a, r_sg_b, r_sg_c, r_sg_d;
    logic [14:0] r_x2_b, r_x2_c;
    logic [29:0] r_inner_c;
    logic [30:0] r_mid_d;
    logic signed [16:0] r_out;

    logic [14:0] n_x;
    logic [29:0] n_x2p;
    logic [41:0] n_cp;
    logic [44:0] n_ip;
    logic [45:0] n_mp;
    logic [16:0] n_mag;

    always_comb begin
        n_x   = i_phase[14] ? 15'(15'd16384 - {1'b0, i_phase[13:0]})
                            : {1'b0, i_phase[13:0]};
        n_x2p = r_x_a * r_x_a;
        n_cp  = r_x2_b * TRIG_C;
        n_ip  = r_x2_c * r_inner_c;
        n_mp  = r_x_d * r_mid_d + 46'd268435456;
        n_mag = {1'b0, n_mp[44:29]};
    end

    // fold phase into the first quadrant, then x2, inner, mid, final term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_a     <= n_x;
            r_sg_a    <= i_phase[15];
            r_x_b     <= r_x_a;
            r_sg_b    <= r_sg_a;
            r_x2_b    <= n_x2p[28:14];
            r_x_c     <= r_x_b;
            r_sg_c    <= r_sg_b;
            r_x2_c    <= r_x2_b;
            r_inner_c <= 30'(TRIG_B - 30'(n_cp[41:14]));
            r_x_d     <= r_x_c;
            r_sg_d    <= r_sg_c;
            r_mid_d   <= 31'(TRIG_A - 31'(n_ip[44:14]));
            r_out     <= r_sg_d ? -$signed(n_mag) : $signed(n_mag);
        end
    end

    assign o_sine = r_out;

endmodule
`default_nettype wire

### rtl/uv_sphere_vertex_generator.sv
`default_nettype none
// throughput: one vertex per cycle while neither output back-pressure nor a reciprocal recompute holds the input,
// set by the fully pipelined divide and trig units
// a write to ring_count recomputes the divider reciprocal serially, holding o_s_tready low until it is done
// reset (synchronous, active low): ring_count = 5, radius = 256, pipeline emptied
module uv_sphere_vertex_generator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire logic [23:0]    i_s_tdata,   // ring_index[7:0], segment_index[16:8]
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic [135:0]        o_m_tdata,   // pos_x, pos_y, pos_z (17b each),
                                             // norm_x, norm_y, norm_z, tex_u, tex_v (16b)
    output logic                o_m_tuser,   // range_error
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import uvs_pkg::*;

    localparam int NSTG = 11;

    logic [7:0]  r_ring;
    logic [15:0] r_radius;
    logic        w_wr;
    t_recip_stat w_rc;
    logic        w_en;
    logic [NSTG-1:0] r_vld;

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_RADIUS) ? {16'd0, r_radius} : {24'd0, r_ring};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring   <= RING_RESET;
            r_radius <= RADIUS_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_RING) begin
                r_ring <= pwdata[7:0];
            end else begin
                r_radius <= pwdata[15:0];
            end
        end
    end

    uvs_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_wr && (paddr[2] == REG_RING)),
        .i_div   ({pwdata[7:0], 1'b0}),
        .o_stat  (w_rc)
    );

    // pipeline advance and handshake
    assign w_en       = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = w_en && !w_rc.busy;
    assign o_m_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid && !w_rc.busy};
        end
    end

    // stage 1: range check and numerators
    logic [7:0]  w_i;
    logic [8:0]  w_j;
    logic        w_err;
    logic [24:0] n_num [4];
    logic [24:0] r_num1 [4];
    logic        r_err [NSTG-1];

    assign w_i   = i_s_tdata[7:0];
    assign w_j   = i_s_tdata[16:8];
    assign w_err = (r_ring < 8'd3) || (w_i > r_ring) || (w_j > {r_ring, 1'b0});

    always_comb begin
        n_num[0] = {1'b0, w_i, 16'd0} + {17'd0, r_ring};
        n_num[1] = {w_j, 16'd0} + {17'd0, r_ring};
        n_num[2] = {1'b0, w_j, 15'd0} + {17'd0, r_ring};
        n_num[3] = {1'b0, 8'(r_ring - w_i), 16'd0} + {17'd0, r_ring};
    end

    // stages 2 to 4: divide by 2N through reciprocal and one correction
    logic [8:0]  w_d;
    logic [56:0] w_prod [4];
    logic [17:0] r_qe2 [4];
    logic [24:0] r_num2 [4];
    logic [26:0] w_chk [4];
    logic [17:0] r_qe3 [4];
    logic [24:0] r_rem3 [4];
    logic [17:0] r_q4 [4];

    assign w_d = {r_ring, 1'b0};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_prod[k] = r_num1[k] * w_rc.recip;
            w_chk[k]  = r_qe2[k] * w_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_num1[k] <= n_num[k];
                r_qe2[k]  <= w_prod[k][49:32];
                r_num2[k] <= r_num1[k];
                r_qe3[k]  <= r_qe2[k];
                r_rem3[k] <= 25'(r_num2[k] - w_chk[k][24:0]);
                r_q4[k]   <= r_qe3[k] + {17'd0, (r_rem3[k] >= {16'd0, w_d})};
            end
            r_err[0] <= w_err;
            for (int s = 1; s < NSTG - 1; s++) begin
                r_err[s] <= r_err[s-1];
            end
        end
    end

    // texture coordinates ride along to the output
    logic [15:0] r_u [4:NSTG-2];
    logic [15:0] r_v [4:NSTG-2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u[4] <= r_q4[2][15:0];
            r_v[4] <= r_q4[3][15:0];
            for (int s = 5; s < NSTG - 1; s++) begin
                r_u[s] <= r_u[s-1];
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // stages 5 to 9: four sine evaluations
    logic signed [16:0] w_dy, w_dxz, w_sl, w_cl;

    uvs_sine u_dy  (.i_clk(i_clk), .i_en(w_en),
                    .i_phase(16'(r_q4[0][15:0] - 16'd16384)), .o_sine(w_dy));
    uvs_sine u_dxz (.i_clk(i_clk), .i_en(w_en), .i_phase(r_q4[0][15:0]), .o_sine(w_dxz));
    uvs_sine u_sl  (.i_clk(i_clk), .i_en(w_en), .i_phase(r_q4[1][15:0]), .o_sine(w_sl));
    uvs_sine u_cl  (.i_clk(i_clk), .i_en(w_en),
                    .i_phase(16'(r_q4[1][15:0] + 16'd16384)), .o_sine(w_cl));

    // stage 10: normals x and z
    logic signed [33:0] w_pnx, w_pnz;
    logic signed [17:0] r_nx, r_nz;
    logic signed [16:0] r_dy;

    assign w_pnx = w_sl * w_dxz + 34'sd16384;
    assign w_pnz = w_cl * w_dxz + 34'sd16384;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx <= 18'(w_pnx >>> 15);
            r_nz <= 18'(w_pnz >>> 15);
            r_dy <= w_dy;
        end
    end

    // stage 11: positions, saturation, error masking
    logic signed [16:0] w_rad;
    logic signed [35:0] w_px, w_py, w_pz;
    logic [135:0] n_out;
    logic         r_uerr;
    logic [135:0] r_out;

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'h7fff;
        end else if (v < -18'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    assign w_rad = $signed({1'b0, r_radius});
    assign w_px  = r_nx * w_rad + 36'sd16384;
    assign w_py  = r_dy * w_rad + 36'sd16384;
    assign w_pz  = r_nz * w_rad + 36'sd16384;

    always_comb begin
        n_out = {5'd0, r_v[NSTG-2], r_u[NSTG-2], sat16(r_nz), sat16({r_dy[16], r_dy}),
                 sat16(r_nx), w_pz[31:15], w_py[31:15], w_px[31:15]};
        if (r_err[NSTG-2]) begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out  <= n_out;
            r_uerr <= r_err[NSTG-2];
        end
    end

    assign o_m_tdata = r_out;
    assign o_m_tuser = r_uerr;

    // a ring count write starts the reciprocal unit and blocks input
    a_recip_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && paddr[2] == REG_RING) |=> (w_rc.busy && !o_s_tready))
        else $error("reciprocal not started on ring count write");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("rejected vertex with nonzero payload");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[114:99] <= 16'd32768
                                        && o_m_tdata[130:115] <= 16'd32768))
        else $error("texture coordinate above one");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rc.busy |=> !r_vld[0] || $past(!w_en))
        else $error("beat taken while reciprocal busy");

endmodule
`default_nettype wire
